[sv/i2c_eeprom_target_model_unit_assert.svh]
// Assertion macros used by the checker file of the I2C EEPROM target model.
// No dependencies; include by bare file name.
`ifndef I2C_EEPROM_TARGET_MODEL_UNIT_ASSERT_SVH
`define I2C_EEPROM_TARGET_MODEL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IEEM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ieem: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IEEM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ieem: next-cycle check failed");

`endif

[sv/ieem_pkg.sv]
// Shared types and constants for the I2C EEPROM target model.
// No dependencies.
package ieem_pkg;

  localparam int unsigned STORE_BYTES = 131072;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned PTR_W       = 18;

  localparam logic [PTR_W-1:0] STORE_END    = PTR_W'(STORE_BYTES);
  localparam logic [PTR_W-1:0] UPPER_OFFSET = 18'h10000;

  localparam logic [7:0] WADDR_HI_MASK  = 8'hF0;
  localparam logic [7:0] TARGET_BASE    = 8'hA0;
  localparam logic [7:0] UPPER_SEL_MASK = 8'h08;
  localparam logic [7:0] ERASED_BYTE    = 8'hFF;
  localparam logic [7:0] ACK_DATA       = 8'h01;
  localparam logic [7:0] NOT_SELECTED   = 8'h00;

  // Byte count within a selection: two address bytes, then data.
  localparam logic [1:0] CNT_ADDR_HI = 2'd0;
  localparam logic [1:0] CNT_ADDR_LO = 2'd1;
  localparam logic [1:0] CNT_DATA    = 2'd2;

  typedef enum logic {
    RESP_ACK  = 1'b0,
    RESP_READ = 1'b1
  } resp_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACK_START,
    ST_WRITE,
    ST_READ_ISSUE,
    ST_READ_EMIT
  } state_t;

  typedef struct packed {
    resp_kind_t kind;
    logic [7:0] address;
    logic [7:0] data;
    logic       last;
  } resp_t;

endpackage

[sv/ieem_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ieem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/ieem_resp.sv]
// Result word register between the sequencer and the out_ channel.
// Depends on ieem_pkg.
module ieem_resp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ieem_pkg::resp_t din,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_stall,
  output ieem_pkg::resp_t dout
);
  import ieem_pkg::*;

  logic  valid_r;
  resp_t data_r;

  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign dout      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= din;
    end
  end

endmodule

[sv/ieem_ctrl.sv]
// Event sequencer: selection, pointer and byte count, store access sequencing.
// Depends on ieem_pkg; drives the byte store RAM and the result register.
module ieem_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cond_start,
  input  logic                        in_cond_stop,
  input  logic                        in_cond_write,
  input  logic                        in_cond_read,
  input  logic [7:0]                  in_wire_address,
  input  logic [7:0]                  in_data_byte,
  input  logic                        resp_ready,
  output logic                        resp_push,
  output ieem_pkg::resp_t             resp,
  output logic                        ram_we,
  output logic [ieem_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata,
  output logic                        ram_re,
  output logic [ieem_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [7:0]                  ram_rdata
);
  import ieem_pkg::*;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0]        sel_addr_r, sel_addr_nxt;
  logic              upper_r, upper_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [7:0]        dbyte_r, dbyte_nxt;
  logic              in_range_r, in_range_nxt;

  logic              accept;
  logic              acc_hit;
  logic [7:0]        acc_sel;
  logic              acc_active;
  logic              ptr_in_range;
  logic [PTR_W-1:0]  ptr_inc;
  logic [PTR_W-1:0]  ptr_lo_load;
  logic [1:0]        cnt_up;

  assign accept  = (state_r == ST_IDLE) && in_valid;
  assign acc_hit = in_cond_start && ((in_wire_address & WADDR_HI_MASK) == TARGET_BASE);

  // Stop acts before start; a start to a foreign address leaves us deselected.
  always_comb begin
    acc_sel = sel_addr_r;
    if (in_cond_stop || in_cond_start) begin
      acc_sel = NOT_SELECTED;
    end
    if (acc_hit) begin
      acc_sel = in_wire_address;
    end
  end

  assign acc_active   = (acc_sel != NOT_SELECTED);
  assign ptr_in_range = (ptr_r < STORE_END);
  assign ptr_inc      = ptr_in_range ? ptr_r + PTR_W'(1) : ptr_r;
  assign ptr_lo_load  = (ptr_r | PTR_W'(dbyte_r)) + (upper_r ? UPPER_OFFSET : '0);
  assign cnt_up       = (cnt_r == CNT_DATA) ? cnt_r : cnt_r + 2'd1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (acc_hit) begin
            state_nxt = ST_ACK_START;
          end else if (acc_active && in_cond_write) begin
            state_nxt = ST_WRITE;
          end else if (acc_active && in_cond_read) begin
            state_nxt = ST_READ_ISSUE;
          end
        end
      end
      ST_ACK_START: begin
        if (resp_ready) begin
          if (wr_pend_r) begin
            state_nxt = ST_WRITE;
          end else if (rd_pend_r) begin
            state_nxt = ST_READ_ISSUE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_WRITE: begin
        if (resp_ready) begin
          state_nxt = rd_pend_r ? ST_READ_ISSUE : ST_IDLE;
        end
      end
      ST_READ_ISSUE: state_nxt = ST_READ_EMIT;
      ST_READ_EMIT: begin
        if (resp_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    sel_addr_nxt = sel_addr_r;
    upper_nxt    = upper_r;
    cnt_nxt      = cnt_r;
    ptr_nxt      = ptr_r;
    wr_pend_nxt  = wr_pend_r;
    rd_pend_nxt  = rd_pend_r;
    dbyte_nxt    = dbyte_r;
    in_range_nxt = in_range_r;
    in_stall     = (state_r != ST_IDLE);
    resp_push    = 1'b0;
    resp.kind    = RESP_ACK;
    resp.address = sel_addr_r;
    resp.data    = ACK_DATA;
    resp.last    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = ERASED_BYTE;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          sel_addr_nxt = acc_sel;
          if (in_cond_stop || in_cond_start) begin
            cnt_nxt = CNT_ADDR_HI;
          end
          if (acc_hit) begin
            upper_nxt = |(in_wire_address & UPPER_SEL_MASK);
          end
          wr_pend_nxt = acc_active && in_cond_write;
          rd_pend_nxt = acc_active && in_cond_read;
          dbyte_nxt   = in_data_byte;
        end
      end
      ST_ACK_START: begin
        resp_push = resp_ready;
        resp.last = !wr_pend_r && !rd_pend_r;
      end
      ST_WRITE: begin
        resp_push = resp_ready;
        resp.last = !rd_pend_r;
        if (resp_ready) begin
          case (cnt_r)
            CNT_ADDR_HI: ptr_nxt = PTR_W'({dbyte_r, 8'h00});
            CNT_ADDR_LO: ptr_nxt = ptr_lo_load;
            default: begin
              // Drop the byte once the pointer has run off the end.
              ram_we    = ptr_in_range;
              ram_waddr = ptr_r[ADDR_W-1:0];
              ram_wdata = dbyte_r;
              ptr_nxt   = ptr_inc;
            end
          endcase
          cnt_nxt = cnt_up;
        end
      end
      ST_READ_ISSUE: begin
        ram_re       = 1'b1;
        ram_raddr    = ptr_r[ADDR_W-1:0];
        in_range_nxt = ptr_in_range;
        ptr_nxt      = ptr_inc;
        cnt_nxt      = cnt_up;
      end
      ST_READ_EMIT: begin
        resp_push = resp_ready;
        resp.kind = RESP_READ;
        resp.data = in_range_r ? ram_rdata : ERASED_BYTE;
        resp.last = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_cnt_r  <= '0;
      sel_addr_r <= NOT_SELECTED;
      upper_r    <= 1'b0;
      cnt_r      <= CNT_ADDR_HI;
      ptr_r      <= '0;
      wr_pend_r  <= 1'b0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      sel_addr_r <= sel_addr_nxt;
      upper_r    <= upper_nxt;
      cnt_r      <= cnt_nxt;
      ptr_r      <= ptr_nxt;
      wr_pend_r  <= wr_pend_nxt;
      rd_pend_r  <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dbyte_r    <= dbyte_nxt;
    in_range_r <= in_range_nxt;
  end

endmodule

[sv/i2c_eeprom_target_model_unit.sv]
// Top level of the bus-event model of a 128 KiB I2C EEPROM target.
// Depends on ieem_pkg, ieem_ram, ieem_ctrl and ieem_resp.
//
// Each in_ word is one bus event (stop, start, write, read, handled in that
// order); each out_ word is one response: a start acknowledge, a write
// acknowledge or a read data byte, with out_last marking the final word of
// the event. The byte store lives in one synchronous RAM of STORE_BYTES
// bytes, so after reset the block first runs a clearing pass that writes
// 0xFF to every entry, one entry per cycle, during which in_stall stays
// high. After that, events are taken one at a time. An event with no
// response leaves the block idle; a start acknowledge is emitted first,
// then a write is acknowledged, its data bytes taking one RAM write port
// slot each, and a read drives the RAM read address and then emits the
// registered read data. A response may wait in the result register while
// out_stall is high. Each write to the store completes before the next
// read is issued, so a read always sees the latest byte at its address.
// Reads past the end of the store return 0xFF, and writes there are dropped.
module i2c_eeprom_target_model_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cond_start,
  input  logic       in_cond_stop,
  input  logic       in_cond_write,
  input  logic       in_cond_read,
  input  logic [7:0] in_wire_address,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_response_kind,
  output logic [7:0] out_response_address,
  output logic [7:0] out_response_data,
  output logic       out_last
);
  import ieem_pkg::*;

  logic              resp_ready;
  logic              resp_push;
  resp_t             resp_in;
  resp_t             resp_out;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Sequence each event: select, write, read; at most one response a cycle.
  ieem_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cond_start   (in_cond_start),
    .in_cond_stop    (in_cond_stop),
    .in_cond_write   (in_cond_write),
    .in_cond_read    (in_cond_read),
    .in_wire_address (in_wire_address),
    .in_data_byte    (in_data_byte),
    .resp_ready      (resp_ready),
    .resp_push       (resp_push),
    .resp            (resp_in),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  // Byte store: one write port, one registered read port.
  ieem_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold each response until the receiver drops out_stall.
  ieem_resp u_resp (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (resp_push),
    .din       (resp_in),
    .ready     (resp_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (resp_out)
  );

  assign out_response_kind    = resp_out.kind;
  assign out_response_address = resp_out.address;
  assign out_response_data    = resp_out.data;
  assign out_last             = resp_out.last;

endmodule

[sv/ieem_checker.sv]
// Port-level checks for the I2C EEPROM target model, bound to the top level.
// Depends on ieem_pkg and the assertion macro header.
`include "i2c_eeprom_target_model_unit_assert.svh"

module ieem_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_response_kind,
  input logic [7:0] out_response_address,
  input logic [7:0] out_response_data,
  input logic       out_last
);
  import ieem_pkg::*;

  logic [17:0] out_word;
  logic        out_ack;
  logic [7:0]  out_addr_hi;

  assign out_word    = {out_response_kind, out_response_address, out_response_data, out_last};
  assign out_ack     = out_valid && (out_response_kind == RESP_ACK);
  assign out_addr_hi = out_response_address & WADDR_HI_MASK;

  // Hold a stalled response word.
  `IEEM_ASSERT_NXT(a_out_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
  `IEEM_ASSERT_NXT(a_out_hold_word, clk, rst_n, out_valid && out_stall, $stable(out_word))

  // Acknowledges always carry the fixed acknowledge byte.
  `IEEM_ASSERT_IMP(a_ack_data, clk, rst_n, out_ack, out_response_data == ACK_DATA)

  // Responses only come while a target address is selected.
  `IEEM_ASSERT_IMP(a_selected_addr, clk, rst_n, out_valid, out_addr_hi == TARGET_BASE)

endmodule

bind i2c_eeprom_target_model_unit ieem_checker u_ieem_checker (.*);
